>>> hdl/mwrt_pkg.sv
// Shared types and constants for the multi-window request throttle.
package mwrt_pkg;

    // Field and register widths
    localparam int TIME_W   = 32;
    localparam int LIMIT_W  = 7;
    localparam int WINDOW_W = 16;
    localparam int RULE_W   = 2;
    localparam int TOTAL_W  = 32;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 16;
    localparam int NRULES   = 3;

    // Result item layout, padded to whole bytes
    localparam int OUT_RAW_W = 1 + RULE_W + TOTAL_W;
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

    // Configuration register indexes
    typedef enum logic [CFG_AW-1:0] {
        CFG_SHORT_LIMIT  = 3'd0,
        CFG_SHORT_WINDOW = 3'd1,
        CFG_MID_LIMIT    = 3'd2,
        CFG_MID_WINDOW   = 3'd3,
        CFG_LONG_LIMIT   = 3'd4,
        CFG_LONG_WINDOW  = 3'd5
    } t_cfg_idx;

    // Rule codes reported with each item
    typedef enum logic [RULE_W-1:0] {
        RULE_PASS  = 2'd0,
        RULE_SHORT = 2'd1,
        RULE_MID   = 2'd2,
        RULE_LONG  = 2'd3
    } t_rule;

    // Register values after reset
    localparam logic [LIMIT_W-1:0]  RST_SHORT_LIMIT  = 7'd3;
    localparam logic [WINDOW_W-1:0] RST_SHORT_WINDOW = 16'd1;
    localparam logic [LIMIT_W-1:0]  RST_MID_LIMIT    = 7'd20;
    localparam logic [WINDOW_W-1:0] RST_MID_WINDOW   = 16'd10;
    localparam logic [LIMIT_W-1:0]  RST_LONG_LIMIT   = 7'd60;
    localparam logic [WINDOW_W-1:0] RST_LONG_WINDOW  = 16'd60;

endpackage

>>> hdl/mwrt_ram.sv
// Simple dual-port RAM: one write port, one registered read port, read-first.
module mwrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write the entry; a read of the same entry returns the old contents
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/multi_window_request_throttle.sv
// Top level of the multi-window request throttle: history ring, rule checks, result register.
//
//  Channel    Direction  Handshake                           Payload
//  s_axis     in         i_s_axis_tvalid / o_s_axis_tready   arrival_time
//  m_axis     out        o_m_axis_tvalid / i_m_axis_tready   dropped, drop_rule, drop_total
//  cfg        in         i_cfg_we (no back-pressure)         register index and value
//
// One item per cycle sustained while results are taken; each item goes through the history RAM
// read and the read stage, then through the compare into the result register.
// The three rules each read their own copy of the history RAM at a look-back set by their limit.
// Reset (i_rst_n low, synchronous) empties the pipeline and restores the registers.
// A stalled result holds the pipeline; o_s_axis_tready drops only when both stages are full.
module multi_window_request_throttle
    import mwrt_pkg::*;
#(
    parameter int HISTORY_DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration write port
    input  logic                i_cfg_we,
    input  logic [CFG_AW-1:0]   i_cfg_addr,
    input  logic [CFG_DW-1:0]   i_cfg_data,
    // Request items
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [TIME_W-1:0]   i_s_axis_tdata,   // [31:0] arrival_time
    // Result items
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [OUT_W-1:0]    o_m_axis_tdata    // [0] dropped, [2:1] drop_rule,
                                                  // [34:3] drop_total, rest zero
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int SW = $clog2(HISTORY_DEPTH + 1);
    localparam int CW = (SW > LIMIT_W) ? SW : LIMIT_W;
    localparam int XW = CW + 1;
    localparam logic [XW-1:0] DEPTH_X = XW'(HISTORY_DEPTH);

    // Configuration registers
    logic [LIMIT_W-1:0]  r_limit  [NRULES];
    logic [WINDOW_W-1:0] r_window [NRULES];

    // Ring state
    logic [AW-1:0]       r_wr_slot;
    logic [SW-1:0]       r_seen;
    logic [TOTAL_W-1:0]  r_drop_cnt;

    // Read stage
    logic                r_s1_valid;
    logic [TIME_W-1:0]   r_s1_now;
    logic [NRULES-1:0]   r_s1_en;

    // Result register
    logic                r_out_valid;
    logic                r_out_dropped;
    t_rule               r_out_rule;
    logic [TOTAL_W-1:0]  r_out_total;

    logic                s_accept;
    logic                s_s1_adv;
    logic [NRULES-1:0]   s_en;
    logic [AW-1:0]       s_raddr [NRULES];
    logic [TIME_W-1:0]   s_past  [NRULES];
    logic [NRULES-1:0]   s_fire;
    t_rule               s_rule;
    logic [TOTAL_W-1:0]  n_drop_cnt;

    // Handshake: the read stage moves on when the result register is free or being taken
    assign s_s1_adv        = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || s_s1_adv;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Configuration writes; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit[0]  <= RST_SHORT_LIMIT;
            r_window[0] <= RST_SHORT_WINDOW;
            r_limit[1]  <= RST_MID_LIMIT;
            r_window[1] <= RST_MID_WINDOW;
            r_limit[2]  <= RST_LONG_LIMIT;
            r_window[2] <= RST_LONG_WINDOW;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SHORT_LIMIT:  r_limit[0]  <= i_cfg_data[LIMIT_W-1:0];
                CFG_SHORT_WINDOW: r_window[0] <= i_cfg_data;
                CFG_MID_LIMIT:    r_limit[1]  <= i_cfg_data[LIMIT_W-1:0];
                CFG_MID_WINDOW:   r_window[1] <= i_cfg_data;
                CFG_LONG_LIMIT:   r_limit[2]  <= i_cfg_data[LIMIT_W-1:0];
                CFG_LONG_WINDOW:  r_window[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Look-back address and enable per rule
    always_comb begin
        logic [XW-1:0] lim_x;
        logic [XW-1:0] seen_x;
        logic [XW-1:0] sum;
        for (int k = 0; k < NRULES; k++) begin
            lim_x  = XW'(r_limit[k]);
            seen_x = XW'(r_seen);
            s_en[k] = (lim_x != '0) && (lim_x <= DEPTH_X) && (seen_x >= lim_x);
            sum = XW'(r_wr_slot) + DEPTH_X - lim_x;
            if (sum >= DEPTH_X) begin
                sum = sum - DEPTH_X;
            end
            s_raddr[k] = sum[AW-1:0];
        end
    end

    // One history copy per rule, all written with the same arrival time
    for (genvar g = 0; g < NRULES; g++) begin : g_hist
        mwrt_ram #(
            .WIDTH (TIME_W),
            .DEPTH (HISTORY_DEPTH)
        ) u_hist (
            .i_clk   (i_clk),
            .i_we    (s_accept),
            .i_waddr (r_wr_slot),
            .i_wdata (i_s_axis_tdata),
            .i_re    (s_accept),
            .i_raddr (s_raddr[g]),
            .o_rdata (s_past[g])
        );
    end

    // Advance the ring on every accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_slot <= '0;
            r_seen    <= '0;
        end else if (s_accept) begin
            if (r_wr_slot == AW'(HISTORY_DEPTH - 1)) begin
                r_wr_slot <= '0;
            end else begin
                r_wr_slot <= r_wr_slot + 1'b1;
            end
            if (r_seen != SW'(HISTORY_DEPTH)) begin
                r_seen <= r_seen + 1'b1;
            end
        end
    end

    // Hold the item while its history reads are in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_now <= i_s_axis_tdata;
            r_s1_en  <= s_en;
        end
    end

    // Compare the elapsed time per rule; the first rule that fires wins
    always_comb begin
        for (int k = 0; k < NRULES; k++) begin
            s_fire[k] = r_s1_en[k] &&
                        ((r_s1_now - s_past[k]) < TIME_W'(r_window[k]));
        end
        if (s_fire[0]) begin
            s_rule = RULE_SHORT;
        end else if (s_fire[1]) begin
            s_rule = RULE_MID;
        end else if (s_fire[2]) begin
            s_rule = RULE_LONG;
        end else begin
            s_rule = RULE_PASS;
        end
        n_drop_cnt = r_drop_cnt;
        if ((s_rule != RULE_PASS) && (r_drop_cnt != '1)) begin
            n_drop_cnt = r_drop_cnt + 1'b1;
        end
    end

    // Drop total and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_s1_adv) begin
                r_drop_cnt  <= n_drop_cnt;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (s_s1_adv) begin
            r_out_dropped <= (s_rule != RULE_PASS);
            r_out_rule    <= s_rule;
            r_out_total   <= n_drop_cnt;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'({r_out_total, r_out_rule, r_out_dropped});

endmodule
